@@ design/modular_square_root_unit_assert.svh @@
// Assertion macros shared by the modular square root design.
`ifndef MODULAR_SQUARE_ROOT_UNIT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/msr_pkg.sv @@
`timescale 1ns / 1ps

package msr_pkg;

    // Top-level sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED,
        ST_EULER,
        ST_FACT,
        ST_XPOW,
        ST_SEARCH,
        ST_AINV,
        ST_CPOW,
        ST_ESQ,
        ST_EMUL,
        ST_CHK,
        ST_XMUL,
        ST_CSQ,
        ST_OUT
    } msr_state_t;

    // Exponentiation unit states.
    typedef enum logic [2:0] {
        EX_IDLE,
        EX_SQ,
        EX_SQ_WAIT,
        EX_ML,
        EX_ML_WAIT
    } msr_exp_state_t;

    // Operation codes of the exponentiation unit.
    typedef enum logic {
        OP_POW,
        OP_MUL
    } msr_op_t;

    // Request to an arithmetic unit.
    typedef struct packed {
        logic    start;
        msr_op_t op;
    } msr_req_t;

    // Status of an arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } msr_sts_t;

endpackage

@@ design/modular_square_root_unit.sv @@
// Run time is data dependent; an exponentiation takes up to 2 * MODULUS_BITS modular
// products. A modulus below three goes from the check state straight to the output state.
// Among the others, items without a root finish soonest, then p = 3 mod 4, then other
// primes, and those take more for a high power of two in p - 1.
// Throughput: one item at a time, taken once the previous result is in the output register.
// Reset: asynchronous, active low, clears the sequencers and the output valid flag.
`timescale 1ns / 1ps

module modular_square_root_unit import msr_pkg::*; #(
    parameter int MODULUS_BITS = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: value_a, modulus_p.
    input  logic [((2*MODULUS_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0: root.
    output logic [((MODULUS_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // Fields from bit 0: has_root.
    output logic                                    m_axis_tuser
);

`include "modular_square_root_unit_assert.svh"

    localparam int N     = MODULUS_BITS;
    localparam int CW    = $clog2(N + 1);
    localparam int OUT_W = ((N + 7) / 8) * 8;

    msr_state_t    state_reg, state_next;
    logic          issued_reg;

    logic [N-1:0]  a_reg, m_reg, s_reg, x_reg, k_reg;
    logic [N-1:0]  ainv_reg, c_reg, e_reg, fin_root_reg;
    logic [CW-1:0] t_reg, rnd_reg, sq_reg;
    logic          fin_has_reg;

    logic          out_valid_reg, out_has_reg;
    logic [N-1:0]  out_root_reg;

    msr_req_t      exp_req;
    msr_sts_t      exp_sts;
    logic [N-1:0]  exp_opa, exp_opb, op_res;

    logic          accept, op_done, go, out_free;
    logic          m_small, m_two, k_in_range, res_is_one, e_is_one, last_rnd;
    logic [N-1:0]  m_minus1, m_minus2, half_m1;

    // Shared exponentiation unit.
    msr_modexp #(
        .W (N)
    ) u_modexp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (exp_req),
        .opa    (exp_opa),
        .opb    (exp_opb),
        .m      (m_reg),
        .sts    (exp_sts),
        .result (op_res)
    );

    // Conditions used by the sequencer.
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign op_done    = exp_sts.done;
    assign go         = !issued_reg;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign m_minus1   = m_reg - N'(1);
    assign m_minus2   = m_reg - N'(2);
    assign half_m1    = m_minus1 >> 1;
    assign m_small    = (m_reg < N'(2));
    assign m_two      = (m_reg == N'(2));
    assign k_in_range = (k_reg < m_reg);
    assign res_is_one = (op_res == N'(1));
    assign e_is_one   = (e_reg == N'(1));
    assign last_rnd   = (rnd_reg == CW'(1));

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (m_small || m_two) ? ST_OUT : ST_RED;
            end
            ST_RED:
            begin
                if (op_done)
                begin
                    state_next = ST_EULER;
                end
            end
            ST_EULER:
            begin
                if (op_done)
                begin
                    state_next = res_is_one ? ST_FACT : ST_OUT;
                end
            end
            ST_FACT:
            begin
                if (s_reg[0])
                begin
                    state_next = ST_XPOW;
                end
            end
            ST_XPOW:
            begin
                if (op_done)
                begin
                    state_next = (t_reg < CW'(2)) ? ST_OUT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (go && !k_in_range)
                begin
                    state_next = ST_AINV;
                end
                else if (op_done && (op_res == m_minus1))
                begin
                    state_next = ST_AINV;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_AINV:
            begin
                if (op_done)
                begin
                    state_next = ST_CPOW;
                end
            end
            ST_CPOW:
            begin
                if (op_done)
                begin
                    state_next = ST_ESQ;
                end
            end
            ST_ESQ:
            begin
                if (op_done)
                begin
                    state_next = ST_EMUL;
                end
            end
            ST_EMUL:
            begin
                if (op_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (go && (sq_reg == '0))
                begin
                    priority if (!e_is_one)
                    begin
                        state_next = ST_XMUL;
                    end
                    else if (last_rnd)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_CSQ;
                    end
                end
            end
            ST_XMUL:
            begin
                if (op_done)
                begin
                    state_next = last_rnd ? ST_OUT : ST_CSQ;
                end
            end
            ST_CSQ:
            begin
                if (op_done)
                begin
                    state_next = ST_ESQ;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input ready and the request to the exponentiation unit.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        exp_req.start = 1'b0;
        exp_req.op    = OP_POW;
        exp_opa       = a_reg;
        exp_opb       = '0;
        unique case (state_reg)
            ST_RED:
            begin
                exp_req.start = go;
                exp_req.op    = OP_MUL;
                exp_opb       = N'(1);
            end
            ST_EULER:
            begin
                exp_req.start = go;
                exp_opb       = half_m1;
            end
            ST_XPOW:
            begin
                exp_req.start = go;
                exp_opb       = (s_reg >> 1) + N'(1);
            end
            ST_SEARCH:
            begin
                exp_req.start = go && k_in_range;
                exp_opa       = k_reg;
                exp_opb       = half_m1;
            end
            ST_AINV:
            begin
                exp_req.start = go;
                exp_opb       = m_minus2;
            end
            ST_CPOW:
            begin
                exp_req.start = go;
                exp_opa       = k_reg;
                exp_opb       = s_reg;
            end
            ST_ESQ:
            begin
                exp_req.start = go;
                exp_req.op    = OP_MUL;
                exp_opa       = x_reg;
                exp_opb       = x_reg;
            end
            ST_EMUL:
            begin
                exp_req.start = go;
                exp_req.op    = OP_MUL;
                exp_opa       = e_reg;
                exp_opb       = ainv_reg;
            end
            ST_CHK:
            begin
                exp_req.start = go && (sq_reg != '0);
                exp_req.op    = OP_MUL;
                exp_opa       = e_reg;
                exp_opb       = e_reg;
            end
            ST_XMUL:
            begin
                exp_req.start = go;
                exp_req.op    = OP_MUL;
                exp_opa       = x_reg;
                exp_opb       = c_reg;
            end
            ST_CSQ:
            begin
                exp_req.start = go;
                exp_req.op    = OP_MUL;
                exp_opa       = c_reg;
                exp_opb       = c_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers: state and the request-in-flight flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exp_req.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (op_done)
            begin
                issued_reg <= 1'b0;
            end
        end
    end

    // Working registers of the root computation.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_reg <= s_axis_tdata[N-1:0];
                    m_reg <= s_axis_tdata[2*N-1:N];
                end
            end
            ST_CHECK:
            begin
                s_reg        <= m_minus1;
                t_reg        <= '0;
                fin_root_reg <= m_two ? N'(a_reg == N'(1)) : '0;
                fin_has_reg  <= m_two;
            end
            ST_RED:
            begin
                if (op_done)
                begin
                    a_reg <= op_res;
                end
            end
            ST_FACT:
            begin
                if (!s_reg[0])
                begin
                    s_reg <= s_reg >> 1;
                    t_reg <= t_reg + CW'(1);
                end
            end
            ST_XPOW:
            begin
                if (op_done)
                begin
                    x_reg        <= op_res;
                    fin_root_reg <= op_res;
                    fin_has_reg  <= 1'b1;
                    k_reg        <= N'(2);
                    rnd_reg      <= t_reg - CW'(1);
                end
            end
            ST_SEARCH:
            begin
                priority if (go && !k_in_range)
                begin
                    k_reg <= '0;
                end
                else if (op_done && (op_res != m_minus1))
                begin
                    k_reg <= k_reg + N'(1);
                end
                else
                begin
                    k_reg <= k_reg;
                end
            end
            ST_AINV:
            begin
                if (op_done)
                begin
                    ainv_reg <= op_res;
                end
            end
            ST_CPOW:
            begin
                if (op_done)
                begin
                    c_reg <= op_res;
                end
            end
            ST_ESQ:
            begin
                if (op_done)
                begin
                    e_reg <= op_res;
                end
            end
            ST_EMUL:
            begin
                if (op_done)
                begin
                    e_reg  <= op_res;
                    sq_reg <= rnd_reg - CW'(1);
                end
            end
            ST_CHK:
            begin
                if (op_done)
                begin
                    e_reg  <= op_res;
                    sq_reg <= sq_reg - CW'(1);
                end
            end
            ST_XMUL:
            begin
                if (op_done)
                begin
                    x_reg        <= op_res;
                    fin_root_reg <= op_res;
                end
            end
            ST_CSQ:
            begin
                if (op_done)
                begin
                    c_reg   <= op_res;
                    rnd_reg <= rnd_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_root_reg <= fin_root_reg;
            out_has_reg  <= fin_has_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_root_reg);
    assign m_axis_tuser  = out_has_reg;

    // Checks on the sequencer.
    `MSR_ASSERT_IMP(a_req_when_idle, clk, rst_n, exp_req.start, !exp_sts.busy && !issued_reg, "request issued while the unit is busy")
    `MSR_ASSERT_NXT(a_mod_stable, clk, rst_n, state_reg != ST_IDLE, $stable(m_reg), "modulus changed during an item")
    `MSR_ASSERT_IMP(a_no_root_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "nonzero root without a root flag")
    `MSR_ASSERT_IMP(a_load_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_OUT), "result loaded outside the output state")

endmodule

@@ design/msr_modmul.sv @@
`timescale 1ns / 1ps

module msr_modmul import msr_pkg::*; #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output msr_sts_t     sts,
    output logic [W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  xs_reg, xs_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W:0]    m_ext, dbl, red1, addend, sum, red2;

    // One interleaved step: acc = 2*acc + bit*y, kept below the modulus.
    always_comb
    begin
        m_ext  = {1'b0, m};
        dbl    = {acc_reg, 1'b0};
        red1   = (dbl >= m_ext) ? dbl - m_ext : dbl;
        addend = xs_reg[W-1] ? {1'b0, y_reg} : '0;
        sum    = red1 + addend;
        red2   = (sum >= m_ext) ? sum - m_ext : sum;
    end

    // The multiplier operand is shifted out MSB first, one bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        y_next    = y_reg;
        if (busy_reg)
        begin
            acc_next = red2[W-1:0];
            xs_next  = {xs_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            acc_next  = '0;
            xs_next   = x;
            y_next    = y;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        xs_reg  <= xs_next;
        y_reg   <= y_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign prod     = acc_reg;

endmodule

@@ design/msr_modexp.sv @@
`timescale 1ns / 1ps

module msr_modexp import msr_pkg::*; #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  msr_req_t     req,
    input  logic [W-1:0] opa,
    input  logic [W-1:0] opb,
    input  logic [W-1:0] m,
    output msr_sts_t     sts,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W + 1);

    msr_exp_state_t state_reg, state_next;
    msr_op_t        op_reg, op_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   exp_reg, exp_next;
    logic [W-1:0]   acc_reg, acc_next;

    logic           mm_start;
    logic [W-1:0]   mm_x, mm_y, mm_prod;
    msr_sts_t       mm_sts;

    logic           bits_left, acc_one, exp_bit;

    assign bits_left = (cnt_reg != '0);
    assign acc_one   = (acc_reg == W'(1));
    assign exp_bit   = exp_reg[W-1];

    // Shared bit-serial multiplier.
    msr_modmul #(
        .W (W)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .m     (m),
        .sts   (mm_sts),
        .prod  (mm_prod)
    );

    // Next state: square, multiply if bit set; OP_MUL multiplies once.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EX_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.op == OP_MUL) ? EX_ML : EX_SQ;
                end
            end
            EX_SQ:
            begin
                if (!bits_left)
                begin
                    state_next = EX_IDLE;
                end
                else if (acc_one)
                begin
                    state_next = EX_ML;
                end
                else
                begin
                    state_next = EX_SQ_WAIT;
                end
            end
            EX_SQ_WAIT:
            begin
                if (mm_sts.done)
                begin
                    state_next = EX_ML;
                end
            end
            EX_ML:
            begin
                state_next = exp_bit ? EX_ML_WAIT : EX_SQ;
            end
            EX_ML_WAIT:
            begin
                if (mm_sts.done)
                begin
                    state_next = (op_reg == OP_MUL) ? EX_IDLE : EX_SQ;
                end
            end
            default:
            begin
                state_next = EX_IDLE;
            end
        endcase
    end

    // Outputs: multiplier start, operand selection and the done pulse.
    always_comb
    begin
        mm_start  = 1'b0;
        mm_x      = base_reg;
        mm_y      = acc_reg;
        done_next = 1'b0;
        unique case (state_reg)
            EX_SQ:
            begin
                mm_start  = bits_left && !acc_one;
                mm_x      = acc_reg;
                done_next = !bits_left;
            end
            EX_ML:
            begin
                mm_start = exp_bit;
            end
            EX_ML_WAIT:
            begin
                done_next = mm_sts.done && (op_reg == OP_MUL);
            end
            default:
            begin
            end
        endcase
    end

    // Data path updates.
    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        unique case (state_reg)
            EX_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    base_next = opa;
                    cnt_next  = CW'(W);
                    if (req.op == OP_MUL)
                    begin
                        acc_next         = opb;
                        exp_next         = '0;
                        exp_next[W-1]    = 1'b1;
                    end
                    else
                    begin
                        acc_next = W'(1);
                        exp_next = opb;
                    end
                end
            end
            EX_SQ_WAIT:
            begin
                if (mm_sts.done)
                begin
                    acc_next = mm_prod;
                end
            end
            EX_ML:
            begin
                if (!exp_bit)
                begin
                    exp_next = {exp_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            EX_ML_WAIT:
            begin
                if (mm_sts.done)
                begin
                    acc_next = mm_prod;
                    exp_next = {exp_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
    end

    assign sts.busy = (state_reg != EX_IDLE);
    assign sts.done = done_reg;
    assign result   = acc_reg;

endmodule

@@ tb/tb_modular_square_root_unit.sv @@
`timescale 1ns / 1ps

module tb_modular_square_root_unit;

    localparam int MODULUS_BITS = 20;
    localparam int IN_W = ((2 * MODULUS_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((MODULUS_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 127;
    localparam int LIMIT_CYCLES = 12_000_000;
    localparam int HOLD_CYCLES = 30_000;
    localparam logic [MODULUS_BITS-1:0] ALL_ONES = '1;

    typedef logic [MODULUS_BITS-1:0] field_t;

    // One result item as the block reports it.
    typedef struct packed {
        field_t root;
        logic   has_root;
    } sqrt_result_t;

    // One row of the directed stimulus. The result is used only when typed is set.
    typedef struct packed {
        logic   typed;
        field_t value_a;
        field_t modulus_p;
        field_t root;
        logic   has_root;
    } directed_row_t;

    // A result still owed by the block, with its operands for the log.
    typedef struct {
        field_t       value_a;
        field_t       modulus_p;
        sqrt_result_t res;
    } pending_root_t;

    localparam int N_DIRECTED = 23;

    // Trivial moduli, extremes and obvious no-root cases carry their result.
    // Primes with long power-of-two chains and a few composites go to the predictor.
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, 20'd0,       20'd0,       20'd0, 1'b0},
        '{1'b1, ALL_ONES,    20'd1,       20'd0, 1'b0},
        '{1'b1, 20'd1,       20'd2,       20'd1, 1'b1},
        '{1'b1, 20'd0,       20'd2,       20'd0, 1'b1},
        '{1'b1, 20'd3,       20'd2,       20'd0, 1'b1},
        '{1'b1, ALL_ONES,    20'd2,       20'd0, 1'b1},
        '{1'b1, 20'd0,       20'd7,       20'd0, 1'b0},
        '{1'b1, ALL_ONES,    ALL_ONES,    20'd0, 1'b0},
        '{1'b1, 20'hAAAAA,   20'h55555,   20'd0, 1'b0},
        '{1'b0, 20'd2,       20'd7,       20'd0, 1'b0},
        '{1'b0, 20'd3,       20'd7,       20'd0, 1'b0},
        '{1'b0, 20'd1,       20'd3,       20'd0, 1'b0},
        '{1'b0, 20'd10,      20'd13,      20'd0, 1'b0},
        '{1'b0, 20'd2,       20'd17,      20'd0, 1'b0},
        '{1'b0, 20'd26,      20'd17,      20'd0, 1'b0},
        '{1'b0, 20'd1000000, 20'd65537,   20'd0, 1'b0},
        '{1'b0, 20'd1000000, 20'd786433,  20'd0, 1'b0},
        '{1'b0, ALL_ONES,    20'd1048573, 20'd0, 1'b0},
        '{1'b0, 20'd1048572, 20'd1048573, 20'd0, 1'b0},
        '{1'b0, 20'd4,       20'd1048573, 20'd0, 1'b0},
        '{1'b0, 20'd5,       20'd1048574, 20'd0, 1'b0},
        '{1'b0, 20'd1,       20'd9,       20'd0, 1'b0},
        '{1'b0, 20'h55555,   20'hAAAAB,   20'd0, 1'b0}
    };

    // Odd composites small enough that a failed non-residue search stays short.
    localparam int unsigned SMALL_COMPOSITES [8] = '{9, 15, 21, 25, 45, 49, 65, 105};

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [IN_W-1:0]  in_data;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] out_data;
    logic             out_user;

    pending_root_t pending_roots[$];
    int            mismatch_count;
    int            items_sent;
    bit            sender_done;

    modular_square_root_unit #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(in_ready),
        .s_axis_tdata (in_data),
        .m_axis_tvalid(out_valid),
        .m_axis_tready(out_ready),
        .m_axis_tdata (out_data),
        .m_axis_tuser (out_user)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Square and multiply, reducing after every step.
    function automatic longint unsigned pow_mod(input longint unsigned base,
                                                input longint unsigned expo,
                                                input longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        longint unsigned e;
        acc = 1 % m;
        b = base % m;
        e = expo;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Tonelli-Shanks root of a modulo p, including the cases for p below three.
    function automatic sqrt_result_t predict_sqrt(input field_t a_in, input field_t p_in);
        longint unsigned m;
        longint unsigned a;
        longint unsigned s;
        longint unsigned t;
        longint unsigned x;
        longint unsigned b;
        longint unsigned k;
        longint unsigned a_inv;
        longint unsigned e;
        longint unsigned pow2k;
        longint unsigned chk;
        sqrt_result_t    r;
        m = p_in;
        a = a_in;
        r = '0;
        if (m < 2)
            return r;
        if (m == 2)
        begin
            r.root = (a == 1) ? field_t'(1) : field_t'(0);
            r.has_root = 1'b1;
            return r;
        end

        // Euler's criterion decides whether any root exists.
        a = a % m;
        if (pow_mod(a, (m - 1) / 2, m) != 1)
            return r;

        // Split p - 1 into an odd part and a power of two.
        s = m - 1;
        t = 0;
        while (s[0] == 1'b0 && s != 0)
        begin
            s = s >> 1;
            t = t + 1;
        end
        x = pow_mod(a, (s + 1) / 2, m);

        // Correction rounds, driven by the first non-residue found.
        if (t >= 2)
        begin
            b = 0;
            for (k = 2; k < m; k++)
            begin
                if (pow_mod(k, (m - 1) / 2, m) == m - 1)
                begin
                    b = k;
                    break;
                end
            end
            a_inv = pow_mod(a, m - 2, m);
            e = (x * x) % m * a_inv % m;
            pow2k = 1;
            for (k = 1; k + 1 <= t; k++)
            begin
                chk = pow_mod(e, longint'(1) << (t - k - 1), m);
                if (chk != 1)
                    x = (x * pow_mod(b, pow2k * s, m)) % m;
                pow2k = pow2k << 1;
                e = (x * x) % m * a_inv % m;
            end
        end
        r.root = x[MODULUS_BITS-1:0];
        r.has_root = 1'b1;
        return r;
    endfunction

    function automatic bit is_prime(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Offers one item, waits for the block to take it and records what it owes.
    // Gaps are skipped inside the calm window so that back-to-back offers occur.
    task automatic offer_item(input field_t a, input field_t p,
                              input bit typed, input sqrt_result_t typed_res);
        pending_root_t entry;
        bit            calm;
        calm = (items_sent >= 30 && items_sent < 60);
        if (!calm && $urandom_range(99, 0) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= IN_W'({p, a});
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        entry.value_a = a;
        entry.modulus_p = p;
        entry.res = typed ? typed_res : predict_sqrt(a, p);
        pending_roots.insert(pending_roots.size(), entry);
        items_sent++;
    endtask

    // Reset, directed table, a drain pause, then random items.
    initial
    begin
        field_t          a;
        field_t          p;
        longint unsigned r;
        int unsigned     kind;
        int unsigned     pick;
        int unsigned     bits;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_count = 0;
        items_sent = 0;
        sender_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer_item(DIRECTED_ROWS[i].value_a, DIRECTED_ROWS[i].modulus_p,
                       DIRECTED_ROWS[i].typed,
                       '{root: DIRECTED_ROWS[i].root, has_root: DIRECTED_ROWS[i].has_root});
        end

        // Hold the input back until the block has answered everything.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_roots.size() != 0);

        // Random part: mostly primes, many with a residue, the rest edge moduli and composites.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 60)
            begin
                bits = ($urandom_range(1, 0) == 1) ? MODULUS_BITS : $urandom_range(19, 2);
                do
                    p = field_t'($urandom_range((1 << bits) - 1, 1 << (bits - 1)) | 1);
                while (!is_prime(p));
                pick = $urandom_range(9, 0);
                if (pick < 6)
                begin
                    r = $urandom_range(p - 1, 0);
                    a = field_t'((r * r) % p);
                end
                else if (pick < 8)
                    a = field_t'($urandom_range(p - 1, 0));
                else
                    a = field_t'($urandom);
            end
            else if (kind < 70)
            begin
                do
                    p = field_t'($urandom_range(63, 3));
                while (!is_prime(p));
                a = field_t'($urandom);
            end
            else if (kind < 78)
            begin
                p = field_t'($urandom_range(2, 0));
                a = ($urandom_range(1, 0) == 1) ? field_t'($urandom_range(3, 0))
                                                : field_t'($urandom);
            end
            else if (kind < 88)
            begin
                p = field_t'($urandom_range(ALL_ONES, 4)) & ~field_t'(1);
                a = field_t'($urandom);
            end
            else if (kind < 94)
            begin
                p = field_t'(SMALL_COMPOSITES[$urandom_range(7, 0)]);
                a = ($urandom_range(1, 0) == 1) ? field_t'(1) : field_t'($urandom);
            end
            else
            begin
                // A large composite of the form 4k+3 never enters the correction rounds.
                do
                    p = field_t'($urandom_range(ALL_ONES, 7) | 3);
                while (is_prime(p));
                a = field_t'($urandom);
            end
            offer_item(a, p, 1'b0, '0);
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;

        // Drain, then leave room for any stray result.
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: checks each item taken and drives ready, with a long hold-off once.
    initial
    begin
        pending_root_t exp_item;
        int            results_seen;
        int            hold_left;
        bit            hold_done;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_roots.size() == 0)
                begin
                    $display("%0t unexpected result: root %h has_root %b",
                             $time, out_data, out_user);
                    mismatch_count++;
                end
                else
                begin
                    exp_item = pending_roots.pop_front();
                    if (out_data !== OUT_W'(exp_item.res.root))
                    begin
                        $display("%0t root mismatch (a %0d, p %0d): expected %h actual %h",
                                 $time, exp_item.value_a, exp_item.modulus_p,
                                 OUT_W'(exp_item.res.root), out_data);
                        mismatch_count++;
                    end
                    if (out_user !== exp_item.res.has_root)
                    begin
                        $display("%0t has_root mismatch (a %0d, p %0d): expected %b actual %b",
                                 $time, exp_item.value_a, exp_item.modulus_p,
                                 exp_item.res.has_root, out_user);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end

            // Start the long hold-off while the sender still has items queued up.
            if (!hold_done && results_seen == 60)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (results_seen >= 20 && results_seen < 50)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99, 0) >= 12);
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
